FILE: src/fpr_pkg.sv
package fpr_pkg;

  // Default sizes
  localparam int FRAME_BYTES_DEF = 64;
  localparam int SLOT_COUNT_DEF  = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;
  localparam logic [1:0] REG_GAP_TIMEOUT  = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [7:0]  START_MARKER_RST = 8'd170;
  localparam logic [7:0]  END_MARKER_RST   = 8'd85;
  localparam logic [5:0]  MAX_PAYLOAD_RST  = 6'd59;
  localparam logic [15:0] GAP_TIMEOUT_RST  = 16'd1000;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_END_CLOSE     = 2'd0;
  localparam logic [1:0] EV_TIMEOUT_CLOSE = 2'd1;
  localparam logic [1:0] EV_OVERFLOW      = 2'd2;
  localparam logic [1:0] EV_BAD_LENGTH    = 2'd3;

  // Packet constants
  localparam logic [7:0]  EMERGENCY_CMD = 8'd25;
  localparam logic [1:0]  ACTION_KIND   = 2'b10;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [5:0]  max_payload;
    logic [15:0] gap_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [2:0] slot;
    logic [7:0] packet_type;
    logic [7:0] payload_len;
    logic [7:0] command_byte;
    logic       checksum_ok;
    logic       emergency;
  } result_t;

endpackage

FILE: src/fpr_cfg_regs.sv
module fpr_cfg_regs
  import fpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  // Write the addressed register, truncated to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= START_MARKER_RST;
      cfg.end_marker   <= END_MARKER_RST;
      cfg.max_payload  <= MAX_PAYLOAD_RST;
      cfg.gap_timeout  <= GAP_TIMEOUT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_START_MARKER: cfg.start_marker <= wr_data[7:0];
        REG_END_MARKER:   cfg.end_marker   <= wr_data[7:0];
        REG_MAX_PAYLOAD:  cfg.max_payload  <= wr_data[5:0];
        REG_GAP_TIMEOUT:  cfg.gap_timeout  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/fpr_in_stage.sv
module fpr_in_stage
  import fpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       s_op,
  input  logic [7:0] s_byte,
  input  logic       advance,
  output logic       in_valid,
  output logic       in_op,
  output logic [7:0] in_byte
);

  logic load;

  // Take a new transaction when nothing is held or the held one moves on
  assign s_tready = !in_valid || advance;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (load) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Hold the payload until the deframer takes it
  always_ff @(posedge clk) begin
    if (load) begin
      in_op   <= s_op;
      in_byte <= s_byte;
    end
  end

endmodule

FILE: src/fpr_deframer.sv
module fpr_deframer
  import fpr_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF
)(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       advance,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam int POS_W  = $clog2(FRAME_BYTES + 1);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic              receiving, receiving_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [7:0]        held_type, held_type_next;
  logic [7:0]        held_length, held_length_next;
  logic [7:0]        held_command, held_command_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        held_checksum, held_checksum_next;
  logic [15:0]       idle_count, idle_count_next;
  logic [SLOT_W-1:0] write_slot, write_slot_next;

  logic              closed;
  logic [8:0]        idx_ext;
  logic [8:0]        check_pos;
  logic [SLOT_W+2:0] slot_ext;

  assign idx_ext   = 9'(byte_position);
  assign check_pos = 9'(held_length_next) + 9'd3;
  assign slot_ext  = {3'b000, write_slot};

  // Work out the next state and the result for the held transaction
  always_comb begin
    receiving_next     = receiving;
    byte_position_next = byte_position;
    held_type_next     = held_type;
    held_length_next   = held_length;
    held_command_next  = held_command;
    running_sum_next   = running_sum;
    held_checksum_next = held_checksum;
    idle_count_next    = idle_count;
    write_slot_next    = write_slot;
    res_valid          = 1'b0;
    closed             = 1'b0;
    res.event_res      = EV_END_CLOSE;
    res.emergency      = 1'b0;

    if (in_op == OP_TICK) begin
      // Count idle time, close an open packet on timeout
      if (idle_count != IDLE_MAX) begin
        idle_count_next = idle_count + 16'd1;
      end
      if (receiving && (idle_count_next >= cfg.gap_timeout)) begin
        res_valid     = 1'b1;
        closed        = 1'b1;
        res.event_res = EV_TIMEOUT_CLOSE;
      end
    end else begin
      idle_count_next = '0;
      if (in_byte == cfg.start_marker) begin
        // Restart the packet
        receiving_next     = 1'b1;
        byte_position_next = POS_W'(1);
        held_type_next     = '0;
        held_length_next   = '0;
        held_command_next  = '0;
        running_sum_next   = '0;
        held_checksum_next = '0;
      end else if (receiving) begin
        if (byte_position >= POS_W'(FRAME_BYTES)) begin
          // Drop on frame overflow
          res_valid     = 1'b1;
          res.event_res = EV_OVERFLOW;
        end else begin
          byte_position_next = byte_position + POS_W'(1);
          if (idx_ext == 9'd1) begin
            held_type_next   = in_byte;
            running_sum_next = running_sum + in_byte;
          end else if (idx_ext == 9'd2) begin
            held_length_next = in_byte;
            running_sum_next = running_sum + in_byte;
          end else begin
            if (idx_ext == 9'd3) begin
              held_command_next = in_byte;
            end
            if (idx_ext < check_pos) begin
              running_sum_next = running_sum + in_byte;
            end else if (idx_ext == check_pos) begin
              held_checksum_next = in_byte;
            end
          end
          // Length limit first, then the end byte
          if (idx_ext >= 9'd2) begin
            if (held_length_next > {2'b00, cfg.max_payload}) begin
              res_valid     = 1'b1;
              res.event_res = EV_BAD_LENGTH;
            end else if (in_byte == cfg.end_marker) begin
              res_valid     = 1'b1;
              closed        = 1'b1;
              res.event_res = EV_END_CLOSE;
              res.emergency = (held_type_next[2:1] == ACTION_KIND) &&
                              (held_command_next == EMERGENCY_CMD);
            end
          end
        end
      end
    end

    if (res_valid) begin
      receiving_next     = 1'b0;
      byte_position_next = '0;
      if (closed) begin
        write_slot_next = (32'(write_slot) + 32'd1 >= 32'(SLOT_COUNT)) ?
                          '0 : write_slot + SLOT_W'(1);
      end
    end

    res.slot         = slot_ext[2:0];
    res.packet_type  = held_type_next;
    res.payload_len  = held_length_next;
    res.command_byte = held_command_next;
    res.checksum_ok  = closed && (running_sum_next == held_checksum_next);
  end

  // Advance the state when the transaction moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      byte_position <= '0;
      held_type     <= '0;
      held_length   <= '0;
      held_command  <= '0;
      running_sum   <= '0;
      held_checksum <= '0;
      idle_count    <= '0;
      write_slot    <= '0;
    end else if (advance) begin
      receiving     <= receiving_next;
      byte_position <= byte_position_next;
      held_type     <= held_type_next;
      held_length   <= held_length_next;
      held_command  <= held_command_next;
      running_sum   <= running_sum_next;
      held_checksum <= held_checksum_next;
      idle_count    <= idle_count_next;
      write_slot    <= write_slot_next;
    end
  end

endmodule

FILE: src/fpr_result_fifo.sv
module fpr_result_fifo
  import fpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    room,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop     = m_valid && m_ready;
  assign m_valid = (count != 2'd0);
  assign room    = (count != 2'd2) || m_ready;
  assign m_res   = entries[rd_ptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the result
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_res;
    end
  end

endmodule

FILE: src/framed_packet_receiver_top.sv
// Channel  Direction  Signals                          Contents
// s_       in         s_tvalid s_tready s_tdata s_tuser received byte or microsecond tick
// m_       out        m_tvalid m_tready m_tdata m_tuser one result per closed or dropped packet
// wr_      in         wr_en wr_index wr_data            configuration writes
//
// One transaction per cycle is taken, sustained while the result queue has room; a result passes
// from its input transaction through the input register, then deframer logic, into the result queue.
// rst is synchronous and clears all control state at once; no clearing pass is needed.
// The result queue holds two results: input keeps flowing while a result waits, and
// stops only once both entries are full and m_tready is low.
module framed_packet_receiver_top
  import fpr_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] rx_byte
  input  logic                   s_tuser,   // [0] operation
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,   // [2:0] slot, [10:3] packet_type,
                                            // [18:11] payload_len, [26:19] command_byte,
                                            // [27] checksum_ok, [28] emergency, [31:29] zero
  output logic [1:0]             m_tuser,   // [1:0] event_res
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  cfg_t       cfg;
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       advance;
  logic       room;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance = in_valid && room;

  fpr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fpr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tuser),
    .s_byte   (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_byte  (in_byte)
  );

  fpr_deframer #(
    .FRAME_BYTES (FRAME_BYTES),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_deframer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .in_op     (in_op),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fpr_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (advance && res_valid),
    .push_res (res),
    .room     (room),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_res    (out_res)
  );

  // Pack the result fields
  assign m_tuser = out_res.event_res;
  assign m_tdata = {3'b000, out_res.emergency, out_res.checksum_ok, out_res.command_byte,
                    out_res.payload_len, out_res.packet_type, out_res.slot};

  // Emergency is raised only by an end-byte close
  a_emergency_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.emergency) |-> (out_res.event_res == EV_END_CLOSE))
    else $error("emergency flag on a result not closed by the end byte");

  // Dropped packets never report a good checksum
  a_drop_no_checksum: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((out_res.event_res == EV_OVERFLOW) ||
                  (out_res.event_res == EV_BAD_LENGTH))) |-> !out_res.checksum_ok)
    else $error("dropped packet reports a valid checksum");

  // Input is open right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> s_tready)
    else $error("input not ready after reset");

endmodule

FILE: sim/framed_packet_receiver_top_tb.sv
module framed_packet_receiver_top_tb
  import fpr_pkg::*;
;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 10;

  // Track the deframer state and hold the packet reports still to come
  class deframer_predictor;
    cfg_t        cfg;
    logic        receiving;
    int unsigned byte_pos;
    logic [7:0]  held_type;
    logic [7:0]  held_length;
    logic [7:0]  held_command;
    logic [7:0]  running_sum;
    logic [7:0]  held_checksum;
    logic [15:0] idle_count;
    logic [2:0]  write_slot;
    result_t     pending_reports[$];
    int unsigned mismatches;

    function new();
      cfg.start_marker = START_MARKER_RST;
      cfg.end_marker   = END_MARKER_RST;
      cfg.max_payload  = MAX_PAYLOAD_RST;
      cfg.gap_timeout  = GAP_TIMEOUT_RST;
      receiving  = 1'b0;
      byte_pos   = 0;
      idle_count = '0;
      write_slot = '0;
      mismatches = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos      = 0;
      held_type     = '0;
      held_length   = '0;
      held_command  = '0;
      running_sum   = '0;
      held_checksum = '0;
    endfunction

    // Queue one report; only a closed packet advances the ring slot
    function void report(logic [1:0] ev, bit closed, bit with_emerg);
      result_t r;
      r.event_res    = ev;
      r.slot         = write_slot;
      r.packet_type  = held_type;
      r.payload_len  = held_length;
      r.command_byte = held_command;
      r.checksum_ok  = closed && (running_sum == held_checksum);
      r.emergency    = closed && with_emerg && (held_type[2:1] == ACTION_KIND)
                       && (held_command == EMERGENCY_CMD);
      pending_reports.push_back(r);
      receiving = 1'b0;
      byte_pos  = 0;
      if (closed)
        write_slot = (write_slot == SLOT_COUNT_DEF - 1) ? '0 : write_slot + 1'b1;
    endfunction

    // Advance the state by one accepted transaction
    function void note_rx(logic op, logic [7:0] b);
      int unsigned idx;
      if (op == OP_TICK) begin
        if (idle_count != IDLE_MAX)
          idle_count++;
        if (receiving && idle_count >= cfg.gap_timeout)
          report(EV_TIMEOUT_CLOSE, 1'b1, 1'b0);
        return;
      end
      idle_count = '0;
      if (b == cfg.start_marker) begin
        clear_packet();
        receiving = 1'b1;
        byte_pos  = 1;
        return;
      end
      if (!receiving)
        return;
      if (byte_pos >= FRAME_BYTES_DEF) begin
        report(EV_OVERFLOW, 1'b0, 1'b0);
        return;
      end
      idx = byte_pos;
      byte_pos++;
      if (idx == 1) begin
        held_type   = b;
        running_sum = running_sum + b;
      end else if (idx == 2) begin
        held_length = b;
        running_sum = running_sum + b;
      end else begin
        if (idx == 3)
          held_command = b;
        if (idx < 3 + held_length)
          running_sum = running_sum + b;
        else if (idx == 3 + held_length)
          held_checksum = b;
      end
      // Length is checked ahead of the end byte
      if (idx >= 2) begin
        if (held_length > cfg.max_payload)
          report(EV_BAD_LENGTH, 1'b0, 1'b0);
        else if (b == cfg.end_marker)
          report(EV_END_CLOSE, 1'b1, 1'b1);
      end
    endfunction

    function void show(string what, result_t r);
      $display("  %s ev=%0d slot=%0d type=%02h len=%02h cmd=%02h ok=%0b em=%0b", what,
               r.event_res, r.slot, r.packet_type, r.payload_len, r.command_byte,
               r.checksum_ok, r.emergency);
    endfunction

    // Compare one report against the oldest one outstanding
    function void check_report(logic [31:0] data, logic [1:0] user);
      result_t got;
      result_t want;
      got.event_res    = user;
      got.slot         = data[2:0];
      got.packet_type  = data[10:3];
      got.payload_len  = data[18:11];
      got.command_byte = data[26:19];
      got.checksum_ok  = data[27];
      got.emergency    = data[28];
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected packet report");
          show("actual  ", got);
        end
        return;
      end
      want = pending_reports.pop_front();
      if (got.event_res !== want.event_res || got.slot !== want.slot
          || got.packet_type !== want.packet_type || got.payload_len !== want.payload_len
          || got.command_byte !== want.command_byte || got.checksum_ok !== want.checksum_ok
          || got.emergency !== want.emergency || data[31:29] !== 3'b000) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("packet report mismatch (pad bits %b)", data[31:29]);
          show("expected", want);
          show("actual  ", got);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [31:0]            m_tdata;
  logic [1:0]             m_tuser;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  deframer_predictor pred = new();
  cfg_t              cur_cfg;
  bit                tx_idle_on = 1'b1;
  bit                rx_idle_on = 1'b1;
  int                hold_requests = 0;
  int                holds_served = 0;
  int                hold_left = 0;
  int                items_sent = 0;
  int                quiet_cycles = 0;

  framed_packet_receiver_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #4 clk = ~clk;

  // Take reports, stall at random, and hold off for a long stretch on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      pred.check_report(m_tdata, m_tuser);
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(rx_idle_on && $urandom_range(0, 99) < 27);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("framed_packet_receiver_top_tb: errors");
      $finish;
    end
  end

  // Offer one transaction, with random gaps ahead of it, and wait for acceptance
  task automatic send_item(input logic op, input logic [7:0] b);
    while (tx_idle_on && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    pred.note_rx(op, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_item(OP_TICK, 8'($urandom));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do
      b = 8'($urandom);
    while (b == cur_cfg.start_marker || b == cur_cfg.end_marker);
    return b;
  endfunction

  function automatic logic [7:0] legal_len();
    logic [7:0] n;
    n = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, cur_cfg.max_payload))
                                    : 8'($urandom_range(0, (cur_cfg.max_payload < 6)
                                                           ? cur_cfg.max_payload : 6));
    return n;
  endfunction

  // Packet: start, type, length, data, checksum (bad unless good_sum), end; ticks may fall among the data
  task automatic send_frame(input bit emerg, input logic [7:0] len, input bit good_sum);
    logic [7:0] kind;
    logic [7:0] sum;
    logic [7:0] d;
    kind = 8'($urandom);
    if (emerg)
      kind[2:1] = ACTION_KIND;
    send_byte(cur_cfg.start_marker);
    send_byte(kind);
    send_byte(len);
    sum = kind + len;
    for (int i = 0; i < len; i++) begin
      d = (emerg && i == 0) ? EMERGENCY_CMD : plain_byte();
      if ($urandom_range(0, 9) == 0)
        send_item(OP_TICK, 8'($urandom));
      sum = sum + d;
      send_byte(d);
    end
    send_byte(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
    send_byte(cur_cfg.end_marker);
  endtask

  // Mostly well-formed packets, the rest broken packets and noise
  task automatic random_traffic(input int n);
    int         target;
    int         pick;
    logic [7:0] len;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame($urandom_range(0, 3) == 0, legal_len(), $urandom_range(0, 99) < 85);
      end else if (pick < 63) begin
        send_byte(cur_cfg.start_marker);
        send_byte(plain_byte());
        send_byte(8'($urandom_range(cur_cfg.max_payload + 1, 255)));
        send_byte(plain_byte());
      end else if (pick < 70) begin
        // fill the frame with no end byte until a byte lands beyond it
        send_byte(cur_cfg.start_marker);
        send_byte(plain_byte());
        len = 8'($urandom_range(0, cur_cfg.max_payload));
        // a tiny length range may hold only marker values; give up after a few tries
        repeat (16)
          if (len == cur_cfg.start_marker || len == cur_cfg.end_marker)
            len = 8'($urandom_range(0, cur_cfg.max_payload));
        send_byte(len);
        repeat (FRAME_BYTES_DEF - 2)
          send_byte(plain_byte());
      end else if (pick < 80) begin
        // truncate the packet, then send at least gap_timeout ticks if it is at most 64, else one to four
        send_byte(cur_cfg.start_marker);
        len = 8'($urandom);
        if ($urandom_range(0, 2) == 0)
          len[2:1] = ACTION_KIND;
        send_byte(len);
        send_byte(legal_len());
        if ($urandom_range(0, 1) == 0)
          send_byte(EMERGENCY_CMD);
        repeat ($urandom_range(0, 2))
          send_byte(plain_byte());
        if (cur_cfg.gap_timeout <= 64)
          send_ticks(cur_cfg.gap_timeout + $urandom_range(0, 2));
        else
          send_ticks($urandom_range(1, 4));
      end else if (pick < 88) begin
        send_byte(cur_cfg.start_marker);
        repeat ($urandom_range(1, 4))
          send_byte(plain_byte());
        send_frame(1'b0, legal_len(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
  endtask

  // Drain outstanding reports, let the pipeline settle, then rewrite every register
  task automatic configure(input cfg_t c);
    s_tvalid <= 1'b0;
    while (pred.pending_reports.size() != 0)
      @(posedge clk);
    repeat (4)
      @(posedge clk);
    write_reg(REG_START_MARKER, CFG_DATA_W'(c.start_marker));
    write_reg(REG_END_MARKER, CFG_DATA_W'(c.end_marker));
    write_reg(REG_MAX_PAYLOAD, CFG_DATA_W'(c.max_payload));
    write_reg(REG_GAP_TIMEOUT, c.gap_timeout);
    wr_en <= 1'b0;
    pred.cfg = c;
    cur_cfg  = c;
  endtask

  initial begin
    cfg_t c;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_BYTE;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    cur_cfg  = pred.cfg;
    repeat (2)
      @(posedge clk);
    rst <= 1'b0;

    // Directed: stray byte and tick, emergency packet, bad length, restart,
    // all-ones type with zero length, bad checksum
    send_byte(8'h00);
    send_item(OP_TICK, 8'hFF);
    send_frame(1'b1, 8'd1, 1'b1);
    send_byte(cur_cfg.start_marker);
    send_byte(8'hFF);
    send_byte(8'd60);
    send_byte(cur_cfg.start_marker);
    send_byte(8'h12);
    send_byte(cur_cfg.start_marker);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_cfg.end_marker);
    send_byte(cur_cfg.start_marker);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(cur_cfg.end_marker);

    // Reset settings
    random_traffic(250);

    // Lowest start byte and length limit, highest end byte, gap of one
    c = '{start_marker: 8'h00, end_marker: 8'hFF, max_payload: 6'd0, gap_timeout: 16'd1};
    configure(c);
    random_traffic(250);

    // Highest length limit, with no idling on either side
    c = '{start_marker: 8'hFF, end_marker: 8'h00, max_payload: 6'd63, gap_timeout: 16'd3};
    configure(c);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(300);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Same start and end byte; back-pressure the reports until the input stalls
    c = '{start_marker: 8'h3C, end_marker: 8'h3C, max_payload: 6'd10, gap_timeout: 16'd5};
    configure(c);
    repeat (40)
      send_frame(1'b0, 8'($urandom_range(0, 2)), 1'b1);
    hold_requests++;
    random_traffic(200);

    // Random settings
    repeat (2) begin
      c.start_marker = 8'($urandom);
      c.end_marker   = 8'($urandom);
      c.max_payload  = 6'($urandom_range(0, 63));
      c.gap_timeout  = 16'($urandom_range(1, 40));
      configure(c);
      random_traffic(250);
    end

    // Zero gap closes on the first tick
    c = '{start_marker: START_MARKER_RST, end_marker: END_MARKER_RST,
          max_payload: MAX_PAYLOAD_RST, gap_timeout: 16'd0};
    configure(c);
    random_traffic(150);

    // Longest gap
    c = '{start_marker: 8'h7E, end_marker: 8'h81, max_payload: 6'd59,
          gap_timeout: IDLE_MAX};
    configure(c);
    random_traffic(200);

    s_tvalid <= 1'b0;
    while (pred.pending_reports.size() != 0)
      @(posedge clk);
    repeat (8)
      @(posedge clk);
    if (pred.mismatches == 0 && pred.pending_reports.size() == 0)
      $display("framed_packet_receiver_top_tb: clean");
    else
      $display("framed_packet_receiver_top_tb: errors");
    $finish;
  end

endmodule

FILE: files.f
src/fpr_pkg.sv
src/fpr_cfg_regs.sv
src/fpr_in_stage.sv
src/fpr_deframer.sv
src/fpr_result_fifo.sv
src/framed_packet_receiver_top.sv
sim/framed_packet_receiver_top_tb.sv
